/* hdl/damped_wave_pixel_filter_assert.svh */
// assertion macros shared by the checker
`ifndef DAMPED_WAVE_PIXEL_FILTER_ASSERT_SVH
`define DAMPED_WAVE_PIXEL_FILTER_ASSERT_SVH

// same-cycle implication, reset masks the check
`define DWP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masks the check
`define DWP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/dwp_pkg.sv */
package dwp_pkg;

	// signed Q10.8 sample
	localparam int QW = 19;
	localparam int NCH = 3;
	localparam int WORDW = QW * NCH;
	typedef logic signed [QW-1:0] q_t;

	// floor division by five via reciprocal on a biased, non-negative sum
	localparam logic [23:0] RECIP5 = 24'd13421773;
	localparam int RECIP5_SHIFT = 26;
	localparam logic signed [21:0] DIV5_BIAS = 22'sd1310720;
	localparam logic signed [20:0] DIV5_OFFSET = 21'sd262144;

	// register reset values
	localparam logic [9:0] FRAME_WIDTH_RST = 10'd320;
	localparam logic [9:0] FRAME_HEIGHT_RST = 10'd240;
	localparam logic [16:0] FRICTION_RST = 17'd62259;
	localparam logic [16:0] SPEED_RST = 17'd13107;

	typedef enum logic [1:0] {
		REG_FRAME_WIDTH = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_FRICTION = 2'd2,
		REG_SPEED = 2'd3
	} reg_index_t;

	// stage load strobes for the channel arithmetic
	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
	} lane_ctl_t;

	// saturate to Q10.8
	function automatic q_t sat_q(input logic signed [25:0] x);
		q_t r;
		if (x > 26'sd262143) begin
			r = 19'sh3FFFF;
		end else if (x < -26'sd262144) begin
			r = 19'sh40000;
		end else begin
			r = x[QW-1:0];
		end
		return r;
	endfunction

	// floor to integer and clamp to 0..255
	function automatic logic [7:0] to_pixel(input q_t h);
		logic [7:0] p;
		if (h[QW-1]) begin
			p = 8'd0;
		end else if (h[17:16] != 2'b00) begin
			p = 8'hFF;
		end else begin
			p = h[15:8];
		end
		return p;
	endfunction

endpackage

/* hdl/dwp_mem.sv */
module dwp_mem import dwp_pkg::*; #(
	parameter int DEPTH = 262144,
	parameter int AW = 18
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WORDW-1:0] h_wdata,
	input  logic [WORDW-1:0] v_wdata,
	input  logic [AW-1:0]    h_raddr,
	input  logic [AW-1:0]    v_raddr,
	output logic [WORDW-1:0] h_rdata,
	output logic [WORDW-1:0] v_rdata
);

	logic [WORDW-1:0] h_mem [DEPTH];
	logic [WORDW-1:0] v_mem [DEPTH];

	// height store
	always_ff @(posedge clk) begin
		if (we) begin
			h_mem[waddr] <= h_wdata;
		end
		h_rdata <= h_mem[h_raddr];
	end

	// velocity store
	always_ff @(posedge clk) begin
		if (we) begin
			v_mem[waddr] <= v_wdata;
		end
		v_rdata <= v_mem[v_raddr];
	end

endmodule

/* hdl/dwp_line.sv */
module dwp_line import dwp_pkg::*; #(
	parameter int DEPTH = 512,
	parameter int CW = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             we,
	input  logic [CW-1:0]    waddr,
	input  logic [WORDW-1:0] wdata,
	input  logic             left_we,
	input  logic [CW-1:0]    raddr,
	output logic [WORDW-1:0] rdata,
	output logic [WORDW-1:0] left_q
);

	logic [WORDW-1:0] line_mem [DEPTH];

	// pre-update heights of the row above
	always_ff @(posedge clk) begin
		if (we) begin
			line_mem[waddr] <= wdata;
		end
		rdata <= line_mem[raddr];
	end

	// pre-update height of the left pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (left_we) begin
			left_q <= wdata;
		end
	end

endmodule

/* hdl/dwp_lane.sv */
module dwp_lane import dwp_pkg::*; (
	input  logic        clk,
	input  lane_ctl_t   ctl,
	input  logic [7:0]  src,
	input  q_t          cur,
	input  q_t          above,
	input  q_t          below,
	input  q_t          left,
	input  q_t          right,
	input  q_t          vel,
	input  logic [16:0] speed,
	input  logic [16:0] friction,
	output q_t          vel_new,
	output q_t          h_new,
	output logic [7:0]  pixel
);

	logic signed [21:0] sum;
	logic [21:0]        biased;
	logic [45:0]        quot_s1;
	logic [19:0]        q5;
	logic signed [20:0] target;
	logic signed [20:0] delta;
	logic signed [38:0] acc_s2;
	logic signed [22:0] accel;
	logic signed [23:0] vsum;
	logic signed [41:0] fr_s3;

	// source plus neighbor sum, biased non-negative, times reciprocal of five
	assign sum = $signed({6'd0, src, 8'd0}) + 22'(above) + 22'(below)
		+ 22'(left) + 22'(right);
	assign biased = 22'(sum + DIV5_BIAS);

	always_ff @(posedge clk) begin
		if (ctl.ld_s1) begin
			quot_s1 <= 46'(biased) * 46'(RECIP5);
		end
	end

	// target minus current height, scaled by speed
	assign q5 = quot_s1[45:RECIP5_SHIFT];
	assign target = $signed({1'b0, q5}) - DIV5_OFFSET;
	assign delta = target - 21'(cur);

	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			acc_s2 <= delta * $signed({1'b0, speed});
		end
	end

	// damped velocity
	assign accel = acc_s2[38:16];
	assign vsum = 24'(vel) + 24'(accel);

	always_ff @(posedge clk) begin
		if (ctl.ld_s3) begin
			fr_s3 <= vsum * $signed({1'b0, friction});
		end
	end

	// saturate and integrate
	assign vel_new = sat_q($signed(fr_s3[41:16]));
	assign h_new = sat_q(26'(cur) + 26'(vel_new));
	assign pixel = to_pixel(h_new);

endmodule

/* hdl/damped_wave_pixel_filter.sv */
// Damped wave ripple filter on an RGB raster stream. Each pixel carries a height and a
// velocity per channel in on-chip memories; every accepted pixel pulls its heights toward
// (source + four neighbor heights) / 5, damps the velocity and returns the new height as an
// 8-bit value, with last_pixel marking the end of a frame. The next pixel is accepted only
// after write-back of the current one: the height memory has one read port and is read three
// times per pixel (own, right and below), followed by three registered multiply steps and the
// write-back, which waits out an output stall. After reset the block clears all entries of its
// stores (MAX_WIDTH * MAX_HEIGHT, 262144 at the defaults) and holds in_stall high meanwhile;
// register writes are taken at any time but should only be made while no pixel is in flight.
module damped_wave_pixel_filter import dwp_pkg::*; #(
	parameter int MAX_WIDTH = 512,
	parameter int MAX_HEIGHT = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  red_in,
	input  logic [7:0]  green_in,
	input  logic [7:0]  blue_in,
	input  logic        frame_start,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  red_out,
	output logic [7:0]  green_out,
	output logic [7:0]  blue_out,
	output logic        last_pixel
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_RD0  = 9'b000000010,
		ST_RD1  = 9'b000000100,
		ST_RD2  = 9'b000001000,
		ST_RD3  = 9'b000010000,
		ST_MUL1 = 9'b000100000,
		ST_MUL2 = 9'b001000000,
		ST_MUL3 = 9'b010000000,
		ST_WB   = 9'b100000000
	} state_t;

	state_t state_q;

	logic [9:0]  frame_width_q;
	logic [9:0]  frame_height_q;
	logic [16:0] friction_q;
	logic [16:0] speed_q;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [AW-1:0] base_q;

	logic [CW-1:0] pix_col_q;
	logic [AW-1:0] idx_q;
	logic          first_row_q;
	logic          first_col_q;
	logic          last_col_q;
	logic          last_row_q;
	logic [7:0]    src_q [NCH];

	logic [AW:0] clr_q;
	logic        clearing;

	logic [WORDW-1:0] cur_q;
	logic [WORDW-1:0] vel_q;
	logic [WORDW-1:0] above_q;
	logic [WORDW-1:0] right_q;
	logic [WORDW-1:0] below_q;

	logic [WORDW-1:0] h_rdata;
	logic [WORDW-1:0] v_rdata;
	logic [WORDW-1:0] line_rdata;
	logic [WORDW-1:0] left_data;
	logic [AW-1:0]    h_raddr;

	logic [WORDW-1:0] h_new_word;
	logic [WORDW-1:0] v_new_word;
	logic [7:0]       pix [NCH];

	logic          in_fire;
	logic          wb_fire;
	logic [CW-1:0] c_now;
	logic [RW-1:0] r_now;
	logic [AW-1:0] base_now;
	logic [CW:0]   w_eff;
	logic [RW:0]   h_eff;
	logic [CW:0]   c_inc;
	logic [RW:0]   r_inc;
	logic          last_col_now;
	logic          last_row_now;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [WORDW-1:0] mem_hw;
	logic [WORDW-1:0] mem_vw;
	logic          line_we;
	logic [CW-1:0] line_waddr;
	logic [WORDW-1:0] line_wdata;

	lane_ctl_t lane_ctl;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
			friction_q <= FRICTION_RST;
			speed_q <= SPEED_RST;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_FRAME_WIDTH:  frame_width_q <= cfg_data[9:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[9:0];
				REG_FRICTION:     friction_q <= cfg_data;
				REG_SPEED:        speed_q <= cfg_data;
			endcase
		end
	end

	// store clearing after reset
	assign clearing = clr_q < (AW+1)'(DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clearing) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// effective frame size
	always_comb begin
		if (frame_width_q == 10'd0) begin
			w_eff = (CW+1)'(1);
		end else if (32'(frame_width_q) > MAX_WIDTH) begin
			w_eff = (CW+1)'(MAX_WIDTH);
		end else begin
			w_eff = (CW+1)'(frame_width_q);
		end
		if (frame_height_q == 10'd0) begin
			h_eff = (RW+1)'(1);
		end else if (32'(frame_height_q) > MAX_HEIGHT) begin
			h_eff = (RW+1)'(MAX_HEIGHT);
		end else begin
			h_eff = (RW+1)'(frame_height_q);
		end
	end

	// position of the incoming pixel
	assign c_now = frame_start ? '0 : col_q;
	assign r_now = frame_start ? '0 : row_q;
	assign base_now = frame_start ? '0 : base_q;
	assign c_inc = {1'b0, c_now} + 1'b1;
	assign r_inc = {1'b0, r_now} + 1'b1;
	assign last_col_now = c_inc >= w_eff;
	assign last_row_now = r_inc >= h_eff;

	assign in_stall = !(state_q == ST_IDLE) || clearing;
	assign in_fire = in_valid && !in_stall;
	assign wb_fire = (state_q == ST_WB) && !(out_valid && out_stall);

	// raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			base_q <= '0;
		end else if (in_fire) begin
			if (last_col_now) begin
				col_q <= '0;
				if (last_row_now) begin
					row_q <= '0;
					base_q <= '0;
				end else begin
					row_q <= r_inc[RW-1:0];
					base_q <= base_now + AW'(MAX_WIDTH);
				end
			end else begin
				col_q <= c_inc[CW-1:0];
				row_q <= r_now;
				base_q <= base_now;
			end
		end
	end

	// per-pixel context of the transaction
	always_ff @(posedge clk) begin
		if (in_fire) begin
			pix_col_q <= c_now;
			idx_q <= base_now + AW'(c_now);
			first_row_q <= r_now == '0;
			first_col_q <= c_now == '0;
			last_col_q <= last_col_now;
			last_row_q <= last_row_now;
			src_q[0] <= red_in;
			src_q[1] <= green_in;
			src_q[2] <= blue_in;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_fire) state_q <= ST_RD0;
				ST_RD0:  state_q <= ST_RD1;
				ST_RD1:  state_q <= ST_RD2;
				ST_RD2:  state_q <= ST_RD3;
				ST_RD3:  state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_MUL3;
				ST_MUL3: state_q <= ST_WB;
				ST_WB:   if (wb_fire) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// height read address: own, right, below
	always_comb begin
		unique case (1'b1)
			state_q == ST_RD1: h_raddr = idx_q + 1'b1;
			state_q == ST_RD2: h_raddr = idx_q + AW'(MAX_WIDTH);
			default:           h_raddr = idx_q;
		endcase
	end

	// capture read data
	always_ff @(posedge clk) begin
		if (state_q == ST_RD1) begin
			cur_q <= h_rdata;
			vel_q <= v_rdata;
			above_q <= line_rdata;
		end
		if (state_q == ST_RD2) begin
			right_q <= h_rdata;
		end
		if (state_q == ST_RD3) begin
			below_q <= h_rdata;
		end
	end

	assign lane_ctl.ld_s1 = state_q == ST_MUL1;
	assign lane_ctl.ld_s2 = state_q == ST_MUL2;
	assign lane_ctl.ld_s3 = state_q == ST_MUL3;

	// one arithmetic lane per color channel, edges clamp to the pixel itself
	for (genvar k = 0; k < NCH; k++) begin : g_lane
		q_t cur_k;
		q_t above_k;
		q_t below_k;
		q_t left_k;
		q_t right_k;
		q_t vel_new_k;
		q_t h_new_k;

		assign cur_k = cur_q[k*QW +: QW];
		assign above_k = first_row_q ? cur_k : above_q[k*QW +: QW];
		assign below_k = last_row_q ? cur_k : below_q[k*QW +: QW];
		assign left_k = first_col_q ? cur_k : left_data[k*QW +: QW];
		assign right_k = last_col_q ? cur_k : right_q[k*QW +: QW];

		dwp_lane u_lane (
			.clk      (clk),
			.ctl      (lane_ctl),
			.src      (src_q[k]),
			.cur      (cur_k),
			.above    (above_k),
			.below    (below_k),
			.left     (left_k),
			.right    (right_k),
			.vel      (vel_q[k*QW +: QW]),
			.speed    (speed_q),
			.friction (friction_q),
			.vel_new  (vel_new_k),
			.h_new    (h_new_k),
			.pixel    (pix[k])
		);

		assign h_new_word[k*QW +: QW] = h_new_k;
		assign v_new_word[k*QW +: QW] = vel_new_k;
	end

	// store write: clearing pass or write-back
	assign mem_we = clearing || wb_fire;
	assign mem_waddr = clearing ? clr_q[AW-1:0] : idx_q;
	assign mem_hw = clearing ? '0 : h_new_word;
	assign mem_vw = clearing ? '0 : v_new_word;

	assign line_we = (clearing && (clr_q < (AW+1)'(MAX_WIDTH))) || wb_fire;
	assign line_waddr = clearing ? clr_q[CW-1:0] : pix_col_q;
	assign line_wdata = clearing ? '0 : cur_q;

	dwp_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.h_wdata (mem_hw),
		.v_wdata (mem_vw),
		.h_raddr (h_raddr),
		.v_raddr (idx_q),
		.h_rdata (h_rdata),
		.v_rdata (v_rdata)
	);

	dwp_line #(
		.DEPTH (MAX_WIDTH),
		.CW    (CW)
	) u_line (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (line_we),
		.waddr   (line_waddr),
		.wdata   (line_wdata),
		.left_we (wb_fire),
		.raddr   (pix_col_q),
		.rdata   (line_rdata),
		.left_q  (left_data)
	);

	// output transaction register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= wb_fire || (out_valid && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (wb_fire) begin
			red_out <= pix[0];
			green_out <= pix[1];
			blue_out <= pix[2];
			last_pixel <= last_col_q && last_row_q;
		end
	end

endmodule

/* hdl/dwp_checker.sv */
`include "damped_wave_pixel_filter_assert.svh"

module dwp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] red_out,
	input logic [7:0] green_out,
	input logic [7:0] blue_out,
	input logic       last_pixel
);

	// a stalled result stays offered
	`DWP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")

	// a stalled result keeps its payload
	`DWP_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
		$stable(red_out) && $stable(green_out) && $stable(blue_out) && $stable(last_pixel),
		"result changed under stall")

	// one pixel in flight at a time
	`DWP_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall,
		"input taken while a pixel is in flight")

	// a result is not offered right after its pixel is accepted
	`DWP_ASSERT_NEXT(a_no_early_result, in_valid && !in_stall && !out_valid, !out_valid,
		"result appeared right after acceptance")

endmodule

bind damped_wave_pixel_filter dwp_checker u_dwp_checker (.*);
